// File: sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [19:0] SKIP_TP = 20'h80000;
    localparam logic [15:0] SKIP_H  = 16'h8000;

    localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
    localparam logic [63:0] P_BASE        = 64'd1048576;
    localparam logic [63:0] P_SCALE       = 64'd3125;
    localparam logic [63:0] P_BIAS_47     = 64'h0000_8000_0000_0000;
    localparam logic [63:0] H_FINE_OFFSET = 64'd76800;
    localparam logic [63:0] H_MAX         = 64'd419430400;
    localparam logic [63:0] H_ROUND_A     = 64'd16384;
    localparam logic [63:0] H_OFS_B       = 64'd32768;
    localparam logic [63:0] H_OFS_C       = 64'd2097152;
    localparam logic [63:0] H_ROUND_C     = 64'd8192;

    typedef enum logic [2:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM_A   = 3'd4,
        REG_HUM_B   = 3'd5
    } esc_reg_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } esc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic               temperature_valid;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
        logic [16:0]        humidity_q22_10;
        logic               humidity_valid;
        logic               divide_error;
    } esc_out_t;

    // Sequencer steps; names ending in M run the shared multiplier.
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T0, ST_T1M, ST_T2, ST_T3M, ST_T4, ST_T5M, ST_T6, ST_T7,
        ST_P0, ST_P1M, ST_P2, ST_P3M, ST_P4, ST_P5M, ST_P6, ST_P7M, ST_P8,
        ST_P9M, ST_P10, ST_P11M, ST_P12, ST_P13, ST_P14, ST_P15M,
        ST_DIV_INIT, ST_DIV_LOOP, ST_DIV_END,
        ST_P17, ST_P18M, ST_P19, ST_P20M, ST_P21, ST_P22M, ST_P23, ST_P24, ST_P25,
        ST_H0, ST_H1M, ST_H2, ST_H3M, ST_H4, ST_H5M, ST_H6, ST_H7M, ST_H8,
        ST_H9M, ST_H10, ST_H11M, ST_H12, ST_H13M, ST_H14, ST_H15M, ST_H16, ST_H17,
        ST_FINISH
    } esc_state_t;

endpackage

// File: sv/env_sensor_compensation_top.sv
`timescale 1ns / 1ps

// Integer compensation of one raw temperature / pressure / humidity triple per
// item, using calibration coefficients written over the APB port (register i
// at byte address 8*i, 64-bit data, lower 48 or 32 bits kept). One item is
// taken at a time: in_stall is low only while the sequencer is idle. The
// pressure step uses a 64-step restoring divider. Every product runs through
// one shared 32x32 multiplier in three passes (low*low, high*low, low*high)
// to form each 64-bit wrapping product. Skipped quantities are passed over;
// only the temperature setup step (ST_T0) is always run. Temperature
// updates the stored fine temperature; pressure and humidity use whatever
// value is stored at that point. A zero pressure divisor raises divide_error
// and suppresses pressure and humidity. The result sits in an output
// register, so a new item can be taken while the last one waits.
module env_sensor_compensation_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  esc_pkg::esc_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output esc_pkg::esc_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esc_pkg::ADDR_W-1:0]    paddr,
    input  logic [esc_pkg::DATA_W-1:0]    pwdata,
    output logic [esc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    function automatic logic [63:0] asr(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    // ---------------- calibration registers ----------------
    logic [47:0] temp_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [31:0] hum_a_reg, hum_b_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg    <= '0;
            press_a_reg <= '0;
            press_b_reg <= '0;
            press_c_reg <= '0;
            hum_a_reg   <= '0;
            hum_b_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                esc_pkg::REG_TEMP:    temp_reg    <= pwdata[47:0];
                esc_pkg::REG_PRESS_A: press_a_reg <= pwdata[47:0];
                esc_pkg::REG_PRESS_B: press_b_reg <= pwdata[47:0];
                esc_pkg::REG_PRESS_C: press_c_reg <= pwdata[47:0];
                esc_pkg::REG_HUM_A:   hum_a_reg   <= pwdata[31:0];
                esc_pkg::REG_HUM_B:   hum_b_reg   <= pwdata[31:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            esc_pkg::REG_TEMP:    prdata = {16'd0, temp_reg};
            esc_pkg::REG_PRESS_A: prdata = {16'd0, press_a_reg};
            esc_pkg::REG_PRESS_B: prdata = {16'd0, press_b_reg};
            esc_pkg::REG_PRESS_C: prdata = {16'd0, press_c_reg};
            esc_pkg::REG_HUM_A:   prdata = {32'd0, hum_a_reg};
            esc_pkg::REG_HUM_B:   prdata = {32'd0, hum_b_reg};
            default:              prdata = '0;
        endcase
    end

    // coefficient fields, extended to the 64-bit datapath
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {48'd0, temp_reg[15:0]};
    assign t2 = sx16(temp_reg[31:16]);
    assign t3 = sx16(temp_reg[47:32]);
    assign p1 = {48'd0, press_a_reg[15:0]};
    assign p2 = sx16(press_a_reg[31:16]);
    assign p3 = sx16(press_a_reg[47:32]);
    assign p4 = sx16(press_b_reg[15:0]);
    assign p5 = sx16(press_b_reg[31:16]);
    assign p6 = sx16(press_b_reg[47:32]);
    assign p7 = sx16(press_c_reg[15:0]);
    assign p8 = sx16(press_c_reg[31:16]);
    assign p9 = sx16(press_c_reg[47:32]);
    assign h1 = {56'd0, hum_a_reg[7:0]};
    assign h2 = sx16(hum_a_reg[23:8]);
    assign h3 = {56'd0, hum_a_reg[31:24]};
    assign h4 = sx12(hum_b_reg[11:0]);
    assign h5 = sx12(hum_b_reg[23:12]);
    assign h6 = sx8(hum_b_reg[31:24]);

    // ---------------- sequencer state ----------------
    esc_pkg::esc_state_t state_reg, state_next;
    esc_pkg::esc_in_t    raw_reg, raw_next;
    esc_pkg::esc_out_t   res_reg, res_next;
    esc_pkg::esc_out_t   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         fine_reg, fine_next;
    logic [63:0]         a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [63:0]         d_reg, d_next, e_reg, e_next;
    logic [63:0]         p_reg, p_next;
    logic [63:0]         acc_reg, acc_next;
    logic [1:0]          ph_reg, ph_next;
    logic [63:0]         rem_reg, rem_next, quo_reg, quo_next, dv_reg, dv_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                neg_reg, neg_next;

    // shared multiplier: one 32x32 pass per cycle
    logic [63:0] mx, my;
    logic        is_mul;
    esc_pkg::esc_state_t mul_after;
    logic [31:0] mx_part, my_part;
    logic [63:0] part;

    assign mx_part = (ph_reg == 2'd1) ? mx[63:32] : mx[31:0];
    assign my_part = (ph_reg == 2'd2) ? my[63:32] : my[31:0];
    assign part    = mx_part * my_part;

    always_comb
    begin
        is_mul    = 1'b1;
        mx        = '0;
        my        = '0;
        mul_after = esc_pkg::ST_IDLE;
        unique case (state_reg)
            esc_pkg::ST_T1M:  begin mx = a_reg; my = t2;      mul_after = esc_pkg::ST_T2;  end
            esc_pkg::ST_T3M:  begin mx = b_reg; my = b_reg;   mul_after = esc_pkg::ST_T4;  end
            esc_pkg::ST_T5M:  begin mx = b_reg; my = t3;      mul_after = esc_pkg::ST_T6;  end
            esc_pkg::ST_P1M:  begin mx = a_reg; my = a_reg;   mul_after = esc_pkg::ST_P2;  end
            esc_pkg::ST_P3M:  begin mx = b_reg; my = p6;      mul_after = esc_pkg::ST_P4;  end
            esc_pkg::ST_P5M:  begin mx = a_reg; my = p5;      mul_after = esc_pkg::ST_P6;  end
            esc_pkg::ST_P7M:  begin mx = b_reg; my = p3;      mul_after = esc_pkg::ST_P8;  end
            esc_pkg::ST_P9M:  begin mx = a_reg; my = p2;      mul_after = esc_pkg::ST_P10; end
            esc_pkg::ST_P11M: begin mx = d_reg; my = p1;      mul_after = esc_pkg::ST_P12; end
            esc_pkg::ST_P15M: begin mx = e_reg; my = esc_pkg::P_SCALE;
                                    mul_after = esc_pkg::ST_DIV_INIT; end
            esc_pkg::ST_P18M: begin mx = c_reg; my = c_reg;   mul_after = esc_pkg::ST_P19; end
            esc_pkg::ST_P20M: begin mx = e_reg; my = p9;      mul_after = esc_pkg::ST_P21; end
            esc_pkg::ST_P22M: begin mx = b_reg; my = p8;      mul_after = esc_pkg::ST_P23; end
            esc_pkg::ST_H1M:  begin mx = a_reg; my = h5;      mul_after = esc_pkg::ST_H2;  end
            esc_pkg::ST_H3M:  begin mx = a_reg; my = h6;      mul_after = esc_pkg::ST_H4;  end
            esc_pkg::ST_H5M:  begin mx = a_reg; my = h3;      mul_after = esc_pkg::ST_H6;  end
            esc_pkg::ST_H7M:  begin mx = d_reg; my = e_reg;   mul_after = esc_pkg::ST_H8;  end
            esc_pkg::ST_H9M:  begin mx = d_reg; my = h2;      mul_after = esc_pkg::ST_H10; end
            esc_pkg::ST_H11M: begin mx = c_reg; my = d_reg;   mul_after = esc_pkg::ST_H12; end
            esc_pkg::ST_H13M: begin mx = c_reg; my = c_reg;   mul_after = esc_pkg::ST_H14; end
            esc_pkg::ST_H15M: begin mx = d_reg; my = h1;      mul_after = esc_pkg::ST_H16; end
            default:          is_mul = 1'b0;
        endcase
    end

    // skip decisions for the latched item
    logic        t_skip, p_skip, h_skip;
    assign t_skip = (raw_reg.raw_temperature == esc_pkg::SKIP_TP);
    assign p_skip = (raw_reg.raw_pressure == esc_pkg::SKIP_TP);
    assign h_skip = (raw_reg.raw_humidity == esc_pkg::SKIP_H);

    // divider step
    logic [63:0] div_shift;
    logic        div_ge;
    assign div_shift = {rem_reg[62:0], quo_reg[63]};
    assign div_ge    = (div_shift >= dv_reg);

    logic [63:0] tsum, t5, t_out, hx;
    logic [63:0] p_clamp_src, h_clamp;

    assign tsum        = a_reg + asr(p_reg, 14);
    assign t5          = (a_reg << 2) + a_reg + 64'd128;
    assign t_out       = asr(t5, 8);
    assign hx          = ({48'd0, raw_reg.raw_humidity} << 14) - (h4 << 20) - p_reg
                         + esc_pkg::H_ROUND_A;
    assign p_clamp_src = e_reg;
    assign h_clamp     = b_reg[63] ? 64'd0 :
                         ((b_reg > esc_pkg::H_MAX) ? esc_pkg::H_MAX : b_reg);

    assign in_stall  = (state_reg != esc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fine_next      = fine_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        ph_next        = 2'd0;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dv_next        = dv_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (is_mul)
        begin
            unique case (ph_reg)
                2'd0:
                begin
                    acc_next = part;
                    ph_next  = 2'd1;
                end
                2'd1:
                begin
                    acc_next = acc_reg + (part << 32);
                    ph_next  = 2'd2;
                end
                default:
                begin
                    p_next     = acc_reg + (part << 32);
                    state_next = mul_after;
                end
            endcase
        end
        else
        begin
            unique case (state_reg)
                esc_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_next   = in_data;
                        res_next   = '0;
                        state_next = esc_pkg::ST_T0;
                    end
                end
                esc_pkg::ST_T0:
                begin
                    a_next = ({44'd0, raw_reg.raw_temperature} >> 3) - (t1 << 1);
                    b_next = ({44'd0, raw_reg.raw_temperature} >> 4) - t1;
                    if (!t_skip)
                        state_next = esc_pkg::ST_T1M;
                    else if (!p_skip)
                        state_next = esc_pkg::ST_P0;
                    else if (!h_skip)
                        state_next = esc_pkg::ST_H0;
                    else
                        state_next = esc_pkg::ST_FINISH;
                end
                esc_pkg::ST_T2:
                begin
                    a_next     = asr(p_reg, 11);
                    state_next = esc_pkg::ST_T3M;
                end
                esc_pkg::ST_T4:
                begin
                    b_next     = asr(p_reg, 12);
                    state_next = esc_pkg::ST_T5M;
                end
                esc_pkg::ST_T6:
                begin
                    fine_next  = tsum[31:0];
                    a_next     = {{32{tsum[31]}}, tsum[31:0]};
                    state_next = esc_pkg::ST_T7;
                end
                esc_pkg::ST_T7:
                begin
                    res_next.temperature_centi = t_out[31:0];
                    res_next.temperature_valid = 1'b1;
                    if (!p_skip)
                        state_next = esc_pkg::ST_P0;
                    else if (!h_skip)
                        state_next = esc_pkg::ST_H0;
                    else
                        state_next = esc_pkg::ST_FINISH;
                end
                esc_pkg::ST_P0:
                begin
                    a_next     = {{32{fine_reg[31]}}, fine_reg} - esc_pkg::T_FINE_OFFSET;
                    state_next = esc_pkg::ST_P1M;
                end
                esc_pkg::ST_P2:
                begin
                    b_next     = p_reg;
                    state_next = esc_pkg::ST_P3M;
                end
                esc_pkg::ST_P4:
                begin
                    c_next     = p_reg;
                    state_next = esc_pkg::ST_P5M;
                end
                esc_pkg::ST_P6:
                begin
                    c_next     = c_reg + (p_reg << 17) + (p4 << 35);
                    state_next = esc_pkg::ST_P7M;
                end
                esc_pkg::ST_P8:
                begin
                    d_next     = asr(p_reg, 8);
                    state_next = esc_pkg::ST_P9M;
                end
                esc_pkg::ST_P10:
                begin
                    d_next     = esc_pkg::P_BIAS_47 + d_reg + (p_reg << 12);
                    state_next = esc_pkg::ST_P11M;
                end
                esc_pkg::ST_P12:
                begin
                    d_next     = asr(p_reg, 33);
                    state_next = esc_pkg::ST_P13;
                end
                esc_pkg::ST_P13:
                begin
                    // zero divisor: flag it, drop pressure and humidity
                    if (d_reg == 64'd0)
                    begin
                        res_next.divide_error = 1'b1;
                        state_next            = esc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        b_next     = esc_pkg::P_BASE - {44'd0, raw_reg.raw_pressure};
                        state_next = esc_pkg::ST_P14;
                    end
                end
                esc_pkg::ST_P14:
                begin
                    e_next     = (b_reg << 31) - c_reg;
                    state_next = esc_pkg::ST_P15M;
                end
                esc_pkg::ST_DIV_INIT:
                begin
                    quo_next   = p_reg[63] ? (64'd0 - p_reg) : p_reg;
                    dv_next    = d_reg[63] ? (64'd0 - d_reg) : d_reg;
                    neg_next   = p_reg[63] ^ d_reg[63];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = esc_pkg::ST_DIV_LOOP;
                end
                esc_pkg::ST_DIV_LOOP:
                begin
                    rem_next = div_ge ? (div_shift - dv_reg) : div_shift;
                    quo_next = {quo_reg[62:0], div_ge};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == '1)
                        state_next = esc_pkg::ST_DIV_END;
                end
                esc_pkg::ST_DIV_END:
                begin
                    b_next     = neg_reg ? (64'd0 - quo_reg) : quo_reg;
                    state_next = esc_pkg::ST_P17;
                end
                esc_pkg::ST_P17:
                begin
                    c_next     = asr(b_reg, 13);
                    state_next = esc_pkg::ST_P18M;
                end
                esc_pkg::ST_P19:
                begin
                    e_next     = p_reg;
                    state_next = esc_pkg::ST_P20M;
                end
                esc_pkg::ST_P21:
                begin
                    e_next     = asr(p_reg, 25);
                    state_next = esc_pkg::ST_P22M;
                end
                esc_pkg::ST_P23:
                begin
                    e_next     = b_reg + e_reg + asr(p_reg, 19);
                    state_next = esc_pkg::ST_P24;
                end
                esc_pkg::ST_P24:
                begin
                    e_next     = asr(e_reg, 8) + (p7 << 4);
                    state_next = esc_pkg::ST_P25;
                end
                esc_pkg::ST_P25:
                begin
                    // negative clamps to zero, above 32 bits to all ones
                    if (p_clamp_src[63])
                        res_next.pressure_q24_8 = '0;
                    else if (p_clamp_src[62:32] != '0)
                        res_next.pressure_q24_8 = '1;
                    else
                        res_next.pressure_q24_8 = p_clamp_src[31:0];
                    res_next.pressure_valid = 1'b1;
                    state_next = h_skip ? esc_pkg::ST_FINISH : esc_pkg::ST_H0;
                end
                esc_pkg::ST_H0:
                begin
                    a_next     = {{32{fine_reg[31]}}, fine_reg} - esc_pkg::H_FINE_OFFSET;
                    state_next = esc_pkg::ST_H1M;
                end
                esc_pkg::ST_H2:
                begin
                    c_next     = asr(hx, 15);
                    state_next = esc_pkg::ST_H3M;
                end
                esc_pkg::ST_H4:
                begin
                    d_next     = asr(p_reg, 10);
                    state_next = esc_pkg::ST_H5M;
                end
                esc_pkg::ST_H6:
                begin
                    e_next     = asr(p_reg, 11) + esc_pkg::H_OFS_B;
                    state_next = esc_pkg::ST_H7M;
                end
                esc_pkg::ST_H8:
                begin
                    d_next     = asr(p_reg, 10) + esc_pkg::H_OFS_C;
                    state_next = esc_pkg::ST_H9M;
                end
                esc_pkg::ST_H10:
                begin
                    d_next     = asr(p_reg + esc_pkg::H_ROUND_C, 14);
                    state_next = esc_pkg::ST_H11M;
                end
                esc_pkg::ST_H12:
                begin
                    b_next     = p_reg;
                    c_next     = asr(p_reg, 15);
                    state_next = esc_pkg::ST_H13M;
                end
                esc_pkg::ST_H14:
                begin
                    d_next     = asr(p_reg, 7);
                    state_next = esc_pkg::ST_H15M;
                end
                esc_pkg::ST_H16:
                begin
                    b_next     = b_reg - asr(p_reg, 4);
                    state_next = esc_pkg::ST_H17;
                end
                esc_pkg::ST_H17:
                begin
                    res_next.humidity_q22_10 = h_clamp[28:12];
                    res_next.humidity_valid  = 1'b1;
                    state_next               = esc_pkg::ST_FINISH;
                end
                esc_pkg::ST_FINISH:
                begin
                    // hand over once the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_next       = res_reg;
                        out_valid_next = 1'b1;
                        state_next     = esc_pkg::ST_IDLE;
                    end
                end
                default:
                    state_next = esc_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            fine_reg      <= '0;
            ph_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fine_reg      <= fine_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        res_reg <= res_next;
        out_reg <= out_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        p_reg   <= p_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dv_reg  <= dv_next;
        neg_reg <= neg_next;
    end

    // ---------------- checks ----------------
    a_div_err_suppresses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_error |->
            !out_data.pressure_valid && !out_data.humidity_valid)
        else $error("divide error with pressure or humidity valid");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == esc_pkg::ST_T0)
        else $error("accepted item did not start the sequencer");

    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg != 2'd0 |-> is_mul && ph_reg != 2'd3)
        else $error("multiplier phase outside a multiply step");

endmodule

// File: dv/env_sensor_compensation_top_test.sv
`timescale 1ns / 1ps

module env_sensor_compensation_top_test;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    esc_pkg::esc_in_t             in_data;
    logic                         out_valid;
    logic                         out_stall;
    esc_pkg::esc_out_t            out_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [esc_pkg::ADDR_W-1:0]   paddr;
    logic [esc_pkg::DATA_W-1:0]   pwdata;
    logic [esc_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    env_sensor_compensation_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Calibration shadow and stored fine temperature, as the block should hold them
    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [31:0] cal_ha, cal_hb;
    logic [31:0] fine_t;

    esc_pkg::esc_out_t pending_q[$];
    int          fail_cnt;
    bit          hold_req;      // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Arithmetic right shift of a 64-bit word (floor)
    function automatic logic [63:0] asr(input logic [63:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sx(input logic [63:0] v, input int w);
        logic [63:0] m;
        m = (64'd1 << w) - 64'd1;
        v = v & m;
        if (v[w-1])
            v = v | ~m;
        return v;
    endfunction

    // Signed 64-bit quotient, truncating; min / -1 wraps
    function automatic logic [63:0] qdiv(input logic [63:0] a, input logic [63:0] b);
        if (b == 64'hFFFF_FFFF_FFFF_FFFF)
            return 64'd0 - a;
        return $signed(a) / $signed(b);
    endfunction

    // Compensates one raw triple and advances the fine temperature
    function automatic esc_pkg::esc_out_t compensate(input esc_pkg::esc_in_t s);
        esc_pkg::esc_out_t r;
        logic [63:0] t1, t2, t3, a, b, v1, v2, tf, p, w1, w2, q, x, y, v;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] h1, h2, h3, h4, h5, h6, at, ap, ah;
        r  = '0;
        at = {44'd0, s.raw_temperature};
        ap = {44'd0, s.raw_pressure};
        ah = {48'd0, s.raw_humidity};
        if (s.raw_temperature != esc_pkg::SKIP_TP)
        begin
            t1 = {48'd0, cal_temp[15:0]};
            t2 = sx(cal_temp[31:16], 16);
            t3 = sx(cal_temp[47:32], 16);
            a  = (at >> 3) - (t1 << 1);
            v1 = asr(a * t2, 11);
            b  = (at >> 4) - t1;
            v2 = asr(asr(b * b, 12) * t3, 14);
            tf = sx(v1 + v2, 32);
            fine_t = tf[31:0];
            v = asr(tf * 64'd5 + 64'd128, 8);
            r.temperature_centi = v[31:0];
            r.temperature_valid = 1'b1;
        end
        if (s.raw_pressure != esc_pkg::SKIP_TP)
        begin
            p1 = {48'd0, cal_pa[15:0]};
            p2 = sx(cal_pa[31:16], 16);
            p3 = sx(cal_pa[47:32], 16);
            p4 = sx(cal_pb[15:0], 16);
            p5 = sx(cal_pb[31:16], 16);
            p6 = sx(cal_pb[47:32], 16);
            p7 = sx(cal_pc[15:0], 16);
            p8 = sx(cal_pc[31:16], 16);
            p9 = sx(cal_pc[47:32], 16);
            v1 = sx(fine_t, 32) - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = asr(((64'd1 << 47) + v1) * p1, 33);
            if (v1 == 64'd0)
                r.divide_error = 1'b1;
            else
            begin
                p  = 64'd1048576 - ap;
                p  = qdiv(((p << 31) - v2) * 64'd3125, v1);
                w1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
                w2 = asr(p8 * p, 19);
                p  = asr(p + w1 + w2, 8) + (p7 << 4);
                if (p[63])
                    p = 64'd0;
                else if (p > 64'hFFFF_FFFF)
                    p = 64'hFFFF_FFFF;
                r.pressure_q24_8 = p[31:0];
                r.pressure_valid = 1'b1;
            end
        end
        if (!r.divide_error && s.raw_humidity != esc_pkg::SKIP_H)
        begin
            h1 = {56'd0, cal_ha[7:0]};
            h2 = sx(cal_ha[23:8], 16);
            h3 = {56'd0, cal_ha[31:24]};
            h4 = sx(cal_hb[11:0], 12);
            h5 = sx(cal_hb[23:12], 12);
            h6 = sx(cal_hb[31:24], 8);
            v = sx(fine_t, 32) - 64'd76800;
            x = asr((ah << 14) - (h4 << 20) - h5 * v + 64'd16384, 15);
            y = asr(asr(v * h6, 10) * (asr(v * h3, 11) + 64'd32768), 10);
            y = asr((y + 64'd2097152) * h2 + 64'd8192, 14);
            v = x * y;
            q = asr(asr(v, 15) * asr(v, 15), 7);
            v = v - asr(q * h1, 4);
            if (v[63])
                v = 64'd0;
            else if (v > 64'd419430400)
                v = 64'd419430400;
            r.humidity_q22_10 = v[28:12];
            r.humidity_valid  = 1'b1;
        end
        return r;
    endfunction

    // APB write: setup then access; also updates the shadow copy
    task automatic write_reg(input esc_pkg::esc_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= esc_pkg::ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            esc_pkg::REG_TEMP:    cal_temp = val[47:0];
            esc_pkg::REG_PRESS_A: cal_pa   = val[47:0];
            esc_pkg::REG_PRESS_B: cal_pb   = val[47:0];
            esc_pkg::REG_PRESS_C: cal_pc   = val[47:0];
            esc_pkg::REG_HUM_A:   cal_ha   = val[31:0];
            esc_pkg::REG_HUM_B:   cal_hb   = val[31:0];
            default: ;
        endcase
    endtask

    // No gap half the time, else mostly a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Sends one item; the prediction is taken at acceptance so that
    // the fine temperature advances in item order. A typed row queues
    // its typed value instead of the prediction.
    task automatic send_item(input esc_pkg::esc_in_t s, input bit typed,
                             input esc_pkg::esc_out_t want);
        esc_pkg::esc_out_t pred;
        int                n;
        n = gap_len();
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = compensate(s);
        pending_q.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    // Realistic calibration set (typical factory values)
    task automatic load_typical();
        write_reg(esc_pkg::REG_TEMP,    {16'd50, 16'd26435, 16'd27504});
        write_reg(esc_pkg::REG_PRESS_A, {16'hF0D0, 16'hD5B7, 16'd36477});
        write_reg(esc_pkg::REG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
        write_reg(esc_pkg::REG_PRESS_C, {16'd6000, 16'hD80A, 16'd15500});
        write_reg(esc_pkg::REG_HUM_A,   {8'd0, 16'd361, 8'd75});
        write_reg(esc_pkg::REG_HUM_B,   {8'd30, 12'd50, 12'd321});
    endtask

    // Random well-formed-ish calibration around typical values, or fully random
    task automatic load_random(input bit wild);
        if (wild)
        begin
            write_reg(esc_pkg::REG_TEMP,    {$urandom(), $urandom()});
            write_reg(esc_pkg::REG_PRESS_A, {$urandom(), $urandom()});
            write_reg(esc_pkg::REG_PRESS_B, {$urandom(), $urandom()});
            write_reg(esc_pkg::REG_PRESS_C, {$urandom(), $urandom()});
            write_reg(esc_pkg::REG_HUM_A,   {$urandom(), $urandom()});
            write_reg(esc_pkg::REG_HUM_B,   {$urandom(), $urandom()});
        end
        else
        begin
            write_reg(esc_pkg::REG_TEMP, {16'($urandom_range(0, 100)),
                16'(26000 + $urandom_range(0, 1000)), 16'(27000 + $urandom_range(0, 1000))});
            write_reg(esc_pkg::REG_PRESS_A, {16'hF0D0 + 16'($urandom_range(0, 200)),
                16'hD5B7 + 16'($urandom_range(0, 200)), 16'(36000 + $urandom_range(0, 900))});
            write_reg(esc_pkg::REG_PRESS_B, {16'hFFF9, 16'($urandom_range(100, 200)),
                16'(2800 + $urandom_range(0, 100))});
            write_reg(esc_pkg::REG_PRESS_C, {16'(5900 + $urandom_range(0, 200)), 16'hD80A,
                16'(15400 + $urandom_range(0, 200))});
            write_reg(esc_pkg::REG_HUM_A, {8'd0, 16'($urandom_range(300, 400)),
                8'($urandom_range(50, 100))});
            write_reg(esc_pkg::REG_HUM_B, {8'($urandom_range(0, 40)),
                12'($urandom_range(0, 60)), 12'($urandom_range(280, 360))});
        end
    endtask

    // Directed rows: raw triple, whether to check a typed value, and that value
    typedef struct {
        esc_pkg::esc_in_t  raw;
        bit                typed;
        esc_pkg::esc_out_t want;
    } row_t;

    function automatic esc_pkg::esc_in_t trip(input logic [19:0] t, input logic [19:0] p,
                                              input logic [15:0] h);
        esc_pkg::esc_in_t s;
        s.raw_temperature = t;
        s.raw_pressure    = p;
        s.raw_humidity    = h;
        return s;
    endfunction

    function automatic esc_pkg::esc_in_t rand_item();
        esc_pkg::esc_in_t s;
        int               k;
        k = $urandom_range(0, 99);
        if (k < 70)
            s = trip(20'($urandom_range(400000, 600000)),
                     20'($urandom_range(250000, 450000)),
                     16'($urandom_range(20000, 40000)));
        else
            s = trip(20'($urandom()), 20'($urandom()), 16'($urandom()));
        if ($urandom_range(0, 9) == 0) s.raw_temperature = esc_pkg::SKIP_TP;
        if ($urandom_range(0, 9) == 0) s.raw_pressure    = esc_pkg::SKIP_TP;
        if ($urandom_range(0, 9) == 0) s.raw_humidity    = esc_pkg::SKIP_H;
        return s;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        esc_pkg::esc_out_t want;
        int                n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (2000)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            n = gap_len();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (out_data !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Timeout: ~1350 items plus gaps and stalls, taken many times over
    initial
    begin
        #(12 * 6000000);
        $display("env_sensor_compensation_top_test NOT OK");
        $finish;
    end

    initial
    begin
        row_t              rows[$];
        esc_pkg::esc_out_t z;
        int                i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        cal_ha = '0; cal_hb = '0;
        fine_t = '0;
        fail_cnt = 0;
        hold_req = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // With all coefficients zero the pressure divisor is zero: divide error,
        // temperature 0 valid, and every skip leaves its field clear.
        z = '0;
        z.temperature_valid = 1'b1;
        z.divide_error = 1'b1;
        rows.push_back('{trip(20'd0, 20'd0, 16'd0), 1'b1, z});
        rows.push_back('{trip(20'hFFFFF, 20'hFFFFF, 16'hFFFF), 1'b1, z});
        z.temperature_valid = 1'b0;
        rows.push_back('{trip(esc_pkg::SKIP_TP, 20'd1234, 16'd100), 1'b1, z});
        z = '0;
        rows.push_back('{trip(esc_pkg::SKIP_TP, esc_pkg::SKIP_TP, esc_pkg::SKIP_H), 1'b1, z});
        // Pressure skipped: no divisor check, humidity computed (0 with zero cal)
        z.humidity_valid = 1'b1;
        rows.push_back('{trip(esc_pkg::SKIP_TP, esc_pkg::SKIP_TP, 16'd0), 1'b1, z});
        foreach (rows[k])
            send_item(rows[k].raw, rows[k].typed, rows[k].want);
        drain();
        rows.delete();

        load_typical();
        rows.push_back('{trip(20'd519888, 20'd415148, 16'd30000), 1'b0, z});
        rows.push_back('{trip(20'd0, 20'd0, 16'd0), 1'b0, z});
        rows.push_back('{trip(20'hFFFFF, 20'hFFFFF, 16'hFFFF), 1'b0, z});
        rows.push_back('{trip(20'h7FFFF, 20'h80001, 16'h7FFF), 1'b0, z});
        rows.push_back('{trip(esc_pkg::SKIP_TP, 20'd415148, 16'd30000), 1'b0, z});
        rows.push_back('{trip(20'd519888, esc_pkg::SKIP_TP, 16'd30000), 1'b0, z});
        rows.push_back('{trip(20'd519888, 20'd415148, esc_pkg::SKIP_H), 1'b0, z});
        rows.push_back('{trip(20'd100, 20'd1, 16'd1), 1'b0, z});
        rows.push_back('{trip(esc_pkg::SKIP_TP, 20'd300000, 16'h8001), 1'b0, z});
        rows.push_back('{trip(20'd700000, 20'd200000, 16'd60000), 1'b0, z});
        foreach (rows[k])
            send_item(rows[k].raw, rows[k].typed, rows[k].want);
        drain();

        // Extremes of every register, then typical settings for the first phase and random ones for the rest
        write_reg(esc_pkg::REG_TEMP,    64'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_A, 64'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_B, 64'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_PRESS_C, 64'hFFFF_FFFF_FFFF);
        write_reg(esc_pkg::REG_HUM_A,   64'hFFFF_FFFF);
        write_reg(esc_pkg::REG_HUM_B,   64'hFFFF_FFFF);
        for (i = 0; i < 30; i++)
            send_item(rand_item(), 1'b0, '0);
        drain();

        for (int ph = 0; ph < 13; ph++)
        begin
            if (ph == 0)
                load_typical();
            else
                load_random(ph % 4 == 3);
            if (ph == 2)
                hold_req = 1'b1;
            for (i = 0; i < 100; i++)
                send_item(rand_item(), 1'b0, '0);
            drain();
        end

        // leftover expectations count as failures
        fail_cnt += pending_q.size();

        if (fail_cnt == 0)
            $display("env_sensor_compensation_top_test OK");
        else
            $display("env_sensor_compensation_top_test NOT OK");
        $finish;
    end

endmodule

// File: files.f
sv/esc_pkg.sv
sv/env_sensor_compensation_top.sv
dv/env_sensor_compensation_top_test.sv
